// ===== design/cwb_pkg.sv =====
package cwb_pkg;

	// field widths fixed by the register map and the stream payload
	localparam int DimW   = 13;
	localparam int PixW   = 32;
	localparam int IdxW   = 24;
	localparam int AddrW  = 5;
	localparam int DataW  = 32;
	localparam int RegSelW = 3;

	// default largest window or framebuffer dimension
	localparam int MaxDimDef = 4096;

	// register indexes, byte address is four times the index
	localparam logic [RegSelW-1:0] RegDestWidth  = 3'd0;
	localparam logic [RegSelW-1:0] RegDestHeight = 3'd1;
	localparam logic [RegSelW-1:0] RegWinX       = 3'd2;
	localparam logic [RegSelW-1:0] RegWinY       = 3'd3;
	localparam logic [RegSelW-1:0] RegWinWidth   = 3'd4;
	localparam logic [RegSelW-1:0] RegWinHeight  = 3'd5;

	// register reset values
	localparam logic [DimW-1:0] DestWidthRst  = 13'd1024;
	localparam logic [DimW-1:0] DestHeightRst = 13'd768;
	localparam logic [DimW-1:0] WinXRst       = 13'd0;
	localparam logic [DimW-1:0] WinYRst       = 13'd0;
	localparam logic [DimW-1:0] WinWidthRst   = 13'd1;
	localparam logic [DimW-1:0] WinHeightRst  = 13'd1;

	// raw register contents as seen by the datapath
	typedef struct packed {
		logic [DimW-1:0] fb_width;
		logic [DimW-1:0] fb_height;
		logic [DimW-1:0] win_x;
		logic [DimW-1:0] win_y;
		logic [DimW-1:0] win_width;
		logic [DimW-1:0] win_height;
	} cfg_t;

	// a zero dimension acts as one, anything above the limit as the limit
	function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v, int unsigned lim);
		logic [31:0] lim_v;
		lim_v = lim;
		if (v == '0)
			return DimW'(1);
		if (32'(v) > lim_v)
			return lim_v[DimW-1:0];
		return v;
	endfunction

endpackage

// ===== design/cwb_regs.sv =====
module cwb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cwb_pkg::AddrW-1:0]   paddr,
	input  logic [cwb_pkg::DataW-1:0]   pwdata,
	output logic [cwb_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	output cwb_pkg::cfg_t               cfg
);
	import cwb_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [RegSelW-1:0] sel;
	logic [DimW-1:0] rd_val;

	assign sel    = paddr[AddrW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write the addressed register in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width    <= DestWidthRst;
			cfg_q.fb_height   <= DestHeightRst;
			cfg_q.win_x       <= WinXRst;
			cfg_q.win_y       <= WinYRst;
			cfg_q.win_width   <= WinWidthRst;
			cfg_q.win_height  <= WinHeightRst;
		end else if (wr_en) begin
			unique case (sel)
				RegDestWidth:  cfg_q.fb_width    <= pwdata[DimW-1:0];
				RegDestHeight: cfg_q.fb_height   <= pwdata[DimW-1:0];
				RegWinX:       cfg_q.win_x       <= pwdata[DimW-1:0];
				RegWinY:       cfg_q.win_y       <= pwdata[DimW-1:0];
				RegWinWidth:   cfg_q.win_width   <= pwdata[DimW-1:0];
				RegWinHeight:  cfg_q.win_height  <= pwdata[DimW-1:0];
				default: ;
			endcase
		end
	end

	// read back the stored value, zero beyond the map
	always_comb begin
		unique case (sel)
			RegDestWidth:  rd_val = cfg_q.fb_width;
			RegDestHeight: rd_val = cfg_q.fb_height;
			RegWinX:       rd_val = cfg_q.win_x;
			RegWinY:       rd_val = cfg_q.win_y;
			RegWinWidth:   rd_val = cfg_q.win_width;
			RegWinHeight:  rd_val = cfg_q.win_height;
			default:       rd_val = '0;
		endcase
	end

	assign prdata = DataW'(rd_val);

endmodule

// ===== design/cwb_walk.sv =====
module cwb_walk #(
	parameter int MAX_DIM = cwb_pkg::MaxDimDef,
	parameter int CW      = $clog2(MAX_DIM)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cwb_pkg::cfg_t             cfg,
	input  logic                      take,
	input  logic                      adv,
	input  logic [cwb_pkg::PixW-1:0]  src_pixel,
	output logic                      s1_valid,
	output logic [cwb_pkg::PixW-1:0]  s1_pixel,
	output logic [CW-1:0]             s1_col,
	output logic [CW-1:0]             s1_row,
	output logic                      s1_last,
	output logic                      cnt_zero,
	output logic                      wrap_now
);
	import cwb_pkg::*;

	localparam int CmpW = ((CW > DimW) ? CW : DimW) + 1;

	logic [CW-1:0] col_q, row_q;
	logic [DimW-1:0] ww, wh;
	logic row_end, last;
	logic valid_s1;
	logic [PixW-1:0] pixel_s1;
	logic [CW-1:0] col_s1, row_s1;
	logic last_s1;

	assign ww = eff_dim(cfg.win_width, MAX_DIM);
	assign wh = eff_dim(cfg.win_height, MAX_DIM);

	// end of row and end of window from the current position
	assign row_end = (CmpW'(col_q) + CmpW'(1)) >= CmpW'(ww);
	assign last    = row_end && ((CmpW'(row_q) + CmpW'(1)) >= CmpW'(wh));

	// advance the raster position on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_s1 <= src_pixel;
			col_s1   <= col_q;
			row_s1   <= row_q;
			last_s1  <= last;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_pixel = pixel_s1;
	assign s1_col   = col_s1;
	assign s1_row   = row_s1;
	assign s1_last  = last_s1;
	assign cnt_zero = (col_q == '0) && (row_q == '0);
	assign wrap_now = last;

endmodule

// ===== design/cwb_clip.sv =====
module cwb_clip #(
	parameter int MAX_DIM = cwb_pkg::MaxDimDef,
	parameter int CW      = $clog2(MAX_DIM)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cwb_pkg::cfg_t             cfg,
	input  logic                      adv,
	input  logic                      s1_valid,
	input  logic [cwb_pkg::PixW-1:0]  s1_pixel,
	input  logic [CW-1:0]             s1_col,
	input  logic [CW-1:0]             s1_row,
	input  logic                      s1_last,
	output logic                      res_valid,
	output logic [cwb_pkg::PixW-1:0]  out_pixel,
	output logic                      visible,
	output logic [cwb_pkg::IdxW-1:0]  dest_index,
	output logic                      last_pixel
);
	import cwb_pkg::*;

	localparam int XW = ((CW + 1 > DimW) ? CW + 1 : DimW) + 2;
	localparam int PW = 2 * DimW;

	logic [DimW-1:0] dw, dh;
	logic signed [XW-1:0] dx, dy;
	logic vis;
	logic [PW-1:0] prod, lin;
	logic [IdxW-1:0] idx;
	logic valid_s2;
	logic [PixW-1:0] pixel_s2;
	logic vis_s2, last_s2;
	logic [IdxW-1:0] idx_s2;

	assign dw = eff_dim(cfg.fb_width, MAX_DIM);
	assign dh = eff_dim(cfg.fb_height, MAX_DIM);

	// destination column and row, signed
	assign dx = XW'(signed'(cfg.win_x)) + XW'(signed'({1'b0, s1_col}));
	assign dy = XW'(signed'(cfg.win_y)) + XW'(signed'({1'b0, s1_row}));

	// clip against the framebuffer
	assign vis = (dx >= 0) && (dx < XW'(signed'({1'b0, dw})))
		&& (dy >= 0) && (dy < XW'(signed'({1'b0, dh})));

	// linear index; a visible row is below dh so it fits the register width
	assign prod = PW'(dy[DimW-1:0]) * PW'(dw);
	assign lin  = prod + PW'(dx[DimW-1:0]);
	assign idx  = vis ? lin[IdxW-1:0] : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= s1_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			pixel_s2 <= s1_pixel;
			vis_s2   <= vis;
			idx_s2   <= idx;
			last_s2  <= s1_last;
		end
	end

	assign res_valid  = valid_s2;
	assign out_pixel  = pixel_s2;
	assign visible    = vis_s2;
	assign dest_index = idx_s2;
	assign last_pixel = last_s2;

endmodule

// ===== design/clipped_window_blit.sv =====
// Channel   Direction  Handshake               Payload
// src       in         src_valid / src_stall   src_pixel
// res       out        res_valid / res_stall   out_pixel, visible, dest_index, last_pixel
// apb       in/out     psel, penable, pready   paddr, pwrite, pwdata, prdata
//
// One pixel a cycle while res is not stalled; a taken pixel passes through the input
// register, then the clip compare and index multiply into the result register, and
// is shown on res from the result register.
// Reset clears the raster counters, both valid bits and restores register defaults.
// A stall on res holds the result register; src stalls only when both stages are full
// and res is stalled.
module clipped_window_blit #(
	parameter int MAX_DIM = cwb_pkg::MaxDimDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        src_valid,
	output logic                        src_stall,
	input  logic [cwb_pkg::PixW-1:0]    src_pixel,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [cwb_pkg::PixW-1:0]    out_pixel,
	output logic                        visible,
	output logic [cwb_pkg::IdxW-1:0]    dest_index,
	output logic                        last_pixel,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cwb_pkg::AddrW-1:0]   paddr,
	input  logic [cwb_pkg::DataW-1:0]   pwdata,
	output logic [cwb_pkg::DataW-1:0]   prdata,
	output logic                        pready
);
	import cwb_pkg::*;

	localparam int CW = $clog2(MAX_DIM);

	cfg_t cfg;
	logic adv1, adv2, take;
	logic s1_valid, s1_last;
	logic [PixW-1:0] s1_pixel;
	logic [CW-1:0] s1_col, s1_row;
	logic cnt_zero, wrap_now;

	// pipeline advance
	assign adv2      = !res_valid || !res_stall;
	assign adv1      = !s1_valid || adv2;
	assign src_stall = !adv1;
	assign take      = src_valid && adv1;

	cwb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cwb_walk #(.MAX_DIM(MAX_DIM), .CW(CW)) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.adv       (adv1),
		.src_pixel (src_pixel),
		.s1_valid  (s1_valid),
		.s1_pixel  (s1_pixel),
		.s1_col    (s1_col),
		.s1_row    (s1_row),
		.s1_last   (s1_last),
		.cnt_zero  (cnt_zero),
		.wrap_now  (wrap_now)
	);

	cwb_clip #(.MAX_DIM(MAX_DIM), .CW(CW)) u_clip (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.adv        (adv2),
		.s1_valid   (s1_valid),
		.s1_pixel   (s1_pixel),
		.s1_col     (s1_col),
		.s1_row     (s1_row),
		.s1_last    (s1_last),
		.res_valid  (res_valid),
		.out_pixel  (out_pixel),
		.visible    (visible),
		.dest_index (dest_index),
		.last_pixel (last_pixel)
	);

	// a clipped pixel carries index zero
	a_clip_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !visible |-> dest_index == '0)
		else $error("clipped pixel with nonzero index");

	// taking the window's last pixel wraps the counters
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		take && wrap_now |=> cnt_zero)
		else $error("counters did not wrap after last pixel");

	// the input stalls only when both stages are full and the output is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> s1_valid && res_valid && res_stall)
		else $error("input stalled with room in the pipeline");

endmodule
